### rtl/gpm_pkg.sv
package gpm_pkg;

  localparam int FIELD_W = 7;

  typedef logic [FIELD_W-1:0] num_t;

  typedef enum logic {
    ACT_ENTRY = 1'b0,
    ACT_CLOSE = 1'b1
  } action_t;

  // Control half of the end-of-set snapshot handed to the search stage
  typedef struct packed {
    logic valid;
    num_t first_unm;
  } snap_ctl_t;

endpackage

### rtl/gpm_if.sv
interface gpm_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  gpm_pkg::num_t     candidate;

  modport source (output valid, output action, output candidate, input ready);
  modport sink   (input valid, input action, input candidate, output ready);
endinterface

interface gpm_out_if;
  logic              valid;
  logic              ready;
  logic              improve;
  gpm_pkg::num_t     requester;
  gpm_pkg::num_t     resource;

  modport source (output valid, output improve, output requester, output resource,
                  input ready);
  modport sink   (input valid, input improve, input requester, input resource,
                  output ready);
endinterface

### rtl/gpm_state.sv
module gpm_state #(
  parameter int MAP_W = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  gpm_pkg::num_t            cfg_wdata,
  input  logic                     in_fire,
  input  logic                     in_action,
  input  gpm_pkg::num_t            in_candidate,
  input  logic                     take,
  output logic                     in_ready,
  output gpm_pkg::snap_ctl_t       snap,
  output logic [MAP_W-1:0]         snap_free
);

  localparam int IDX_W = (MAP_W > 1) ? $clog2(MAP_W) : 1;
  localparam gpm_pkg::num_t MAP_LIM = gpm_pkg::num_t'(MAP_W);

  gpm_pkg::num_t      group_r;
  gpm_pkg::num_t      eff_g;
  logic [MAP_W-1:0]   taken_r, taken_nxt;
  gpm_pkg::num_t      cur_r, cur_nxt;
  logic               matched_r, matched_nxt;
  gpm_pkg::num_t      fu_r, fu_nxt;
  gpm_pkg::num_t      fu_new;
  logic               snap_v_r, snap_v_nxt;
  gpm_pkg::num_t      snap_fu_r, snap_fu_nxt;
  logic [MAP_W-1:0]   snap_free_r, snap_free_nxt;
  logic [MAP_W-1:0]   gmask;
  logic               cand_ok;
  logic [IDX_W-1:0]   cand_idx;

  // Clamp the configured size into 1..MAP_W
  always_comb begin
    if (group_r == '0) begin
      eff_g = gpm_pkg::num_t'(1);
    end else if (group_r > MAP_LIM) begin
      eff_g = MAP_LIM;
    end else begin
      eff_g = group_r;
    end
  end

  always_comb begin
    for (int i = 0; i < MAP_W; i++) begin
      gmask[i] = (gpm_pkg::num_t'(i) < eff_g);
    end
  end

  assign cand_ok  = (in_candidate != '0) && (in_candidate <= eff_g);
  assign cand_idx = IDX_W'(in_candidate - gpm_pkg::num_t'(1));
  assign fu_new   = ((fu_r == '0) && !matched_r) ? cur_r : fu_r;

  assign in_ready = !snap_v_r || take;

  always_comb begin
    taken_nxt     = taken_r;
    cur_nxt       = cur_r;
    matched_nxt   = matched_r;
    fu_nxt        = fu_r;
    snap_v_nxt    = snap_v_r && !take;
    snap_fu_nxt   = snap_fu_r;
    snap_free_nxt = snap_free_r;
    if (in_fire) begin
      unique case (in_action)
        gpm_pkg::ACT_ENTRY: begin
          if (!matched_r && cand_ok && !taken_r[cand_idx]) begin
            taken_nxt[cand_idx] = 1'b1;
            matched_nxt         = 1'b1;
          end
        end
        gpm_pkg::ACT_CLOSE: begin
          if (cur_r < eff_g) begin
            cur_nxt     = cur_r + gpm_pkg::num_t'(1);
            matched_nxt = 1'b0;
            fu_nxt      = fu_new;
          end else begin
            // Last list closed: hand the set to the search stage and clear
            snap_v_nxt    = 1'b1;
            snap_fu_nxt   = fu_new;
            snap_free_nxt = ~taken_r & gmask;
            taken_nxt     = '0;
            cur_nxt       = gpm_pkg::num_t'(1);
            matched_nxt   = 1'b0;
            fu_nxt        = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r   <= gpm_pkg::num_t'(1);
      taken_r   <= '0;
      cur_r     <= gpm_pkg::num_t'(1);
      matched_r <= 1'b0;
      fu_r      <= '0;
      snap_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        group_r <= cfg_wdata;
      end
      taken_r   <= taken_nxt;
      cur_r     <= cur_nxt;
      matched_r <= matched_nxt;
      fu_r      <= fu_nxt;
      snap_v_r  <= snap_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_fu_r   <= snap_fu_nxt;
    snap_free_r <= snap_free_nxt;
  end

  assign snap.valid     = snap_v_r;
  assign snap.first_unm = snap_fu_r;
  assign snap_free      = snap_free_r;

endmodule

### rtl/gpm_search.sv
module gpm_search #(
  parameter int MAP_W = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gpm_pkg::snap_ctl_t   snap,
  input  logic [MAP_W-1:0]     snap_free,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_improve,
  output gpm_pkg::num_t        out_requester,
  output gpm_pkg::num_t        out_resource
);

  logic            out_v_r, out_v_nxt;
  logic            improve_r, improve_nxt;
  gpm_pkg::num_t   req_r, req_nxt;
  gpm_pkg::num_t   res_r, res_nxt;
  gpm_pkg::num_t   low_free;
  logic            any_free;

  // Lowest free resource, numbered from one
  always_comb begin
    low_free = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (snap_free[i]) begin
        low_free = gpm_pkg::num_t'(i + 1);
      end
    end
  end

  assign any_free = |snap_free;
  assign take     = !out_v_r || out_ready;

  always_comb begin
    out_v_nxt   = out_v_r && !out_ready;
    improve_nxt = improve_r;
    req_nxt     = req_r;
    res_nxt     = res_r;
    if (take && snap.valid) begin
      out_v_nxt = 1'b1;
      if ((snap.first_unm != '0) && any_free) begin
        improve_nxt = 1'b1;
        req_nxt     = snap.first_unm;
        res_nxt     = low_free;
      end else begin
        improve_nxt = 1'b0;
        req_nxt     = '0;
        res_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    improve_r <= improve_nxt;
    req_r     <= req_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_improve   = improve_r;
  assign out_requester = req_r;
  assign out_resource  = res_r;

endmodule

### rtl/greedy_preference_matcher_top.sv
// Channel  | Direction | Payload                          | Transaction
// in_ch    | in        | action, candidate                | valid && ready
// out_ch   | out       | improve, requester, resource     | valid && ready
// cfg_*    | in        | group_size (cfg_wdata)           | cfg_we
//
// One item per cycle while in_ch.ready is high; each entry or close updates the set state in the cycle it is taken.
// Closing the last list yields its result through the snapshot register, then the
// lowest-free-resource encoder into the output register.
// The set state clears as the last close is taken, so the next item starts a new set.
// Synchronous active-low reset: group_size = 1, no resources taken, requester 1.
// A stalled output holds one result and the snapshot holds another; in_ch.ready drops
// only while both are occupied.
module greedy_preference_matcher_top #(
  parameter int MAX_GROUP = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  gpm_pkg::num_t     cfg_wdata,
  gpm_in_if.sink            in_ch,
  gpm_out_if.source         out_ch
);

  // Resource numbers are limited by the field width
  localparam int NUM_MAX = (1 << gpm_pkg::FIELD_W) - 1;
  localparam int MAP_W   = (MAX_GROUP < NUM_MAX) ? MAX_GROUP : NUM_MAX;

  logic                 in_fire;
  logic                 in_ready;
  logic                 st_ready;
  logic                 take;
  gpm_pkg::snap_ctl_t   snap;
  logic [MAP_W-1:0]     snap_free;

  assign in_ready    = st_ready;
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  gpm_state #(
    .MAP_W (MAP_W)
  ) u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_fire      (in_fire),
    .in_action    (in_ch.action),
    .in_candidate (in_ch.candidate),
    .take         (take),
    .in_ready     (st_ready),
    .snap         (snap),
    .snap_free    (snap_free)
  );

  gpm_search #(
    .MAP_W (MAP_W)
  ) u_search (
    .clk           (clk),
    .rst_n         (rst_n),
    .snap          (snap),
    .snap_free     (snap_free),
    .take          (take),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_improve   (out_ch.improve),
    .out_requester (out_ch.requester),
    .out_resource  (out_ch.resource)
  );

  a_improve_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.improve |->
      (out_ch.requester != '0) && (out_ch.resource != '0))
    else $error("improve result with a zero requester or resource");

  a_optimal_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.improve |->
      (out_ch.requester == '0) && (out_ch.resource == '0))
    else $error("optimal result with nonzero fields");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> snap.valid && out_ch.valid && !out_ch.ready)
    else $error("input stalled without a held result");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    snap.valid && !out_ch.valid |=> out_ch.valid)
    else $error("snapshot not moved into an empty output register");

endmodule

### tb/greedy_preference_matcher_top_test.sv
typedef struct {
  logic          improve;
  gpm_pkg::num_t requester;
  gpm_pkg::num_t resource;
} verdict_t;

class match_tracker;
  logic [63:0]            taken;
  int unsigned            cur_req;
  bit                     cur_matched;
  int unsigned            first_unm;
  gpm_pkg::num_t          group_size;
  verdict_t               pending_verdicts[$];
  int unsigned            fails;

  function new();
    group_size = gpm_pkg::num_t'(1);
    fails = 0;
    clear_set();
  endfunction

  function void clear_set();
    taken = '0;
    cur_req = 1;
    cur_matched = 0;
    first_unm = 0;
  endfunction

  // Zero acts as one; anything past 64 saturates.
  function int unsigned span();
    if (group_size == 0) return 1;
    if (group_size > 64) return 64;
    return 32'(group_size);
  endfunction

  function void set_group(gpm_pkg::num_t v);
    group_size = v;
  endfunction

  function int unsigned waiting();
    return pending_verdicts.size();
  endfunction

  function void note_item(gpm_pkg::action_t act, gpm_pkg::num_t cand);
    int unsigned g;
    int unsigned free_res;
    verdict_t v;
    g = span();
    free_res = 0;
    if (act == gpm_pkg::ACT_ENTRY) begin
      if (!cur_matched && cand >= 1 && cand <= g && !taken[cand-1]) begin
        taken[cand-1] = 1'b1;
        cur_matched = 1;
      end
      return;
    end
    if (!cur_matched && first_unm == 0) first_unm = cur_req;
    if (cur_req < g) begin
      cur_req++;
      cur_matched = 0;
      return;
    end
    if (first_unm != 0) begin
      for (int unsigned r = 1; r <= g; r++) begin
        if (!taken[r-1]) begin
          free_res = r;
          break;
        end
      end
    end
    if (first_unm != 0 && free_res != 0) begin
      v.improve = 1'b1;
      v.requester = gpm_pkg::num_t'(first_unm);
      v.resource = gpm_pkg::num_t'(free_res);
    end else begin
      v.improve = 1'b0;
      v.requester = '0;
      v.resource = '0;
    end
    pending_verdicts.insert(pending_verdicts.size(), v);
    clear_set();
  endfunction

  function void check_verdict(logic improve, gpm_pkg::num_t rq, gpm_pkg::num_t rs);
    verdict_t v;
    if (pending_verdicts.size() == 0) begin
      $error("unexpected result: improve %0d requester %0d resource %0d", improve, rq, rs);
      fails++;
      return;
    end
    v = pending_verdicts.pop_front();
    if (improve !== v.improve) begin
      $error("improve: expected %0d, actual %0d", v.improve, improve);
      fails++;
    end
    if (rq !== v.requester) begin
      $error("requester: expected %0d, actual %0d", v.requester, rq);
      fails++;
    end
    if (rs !== v.resource) begin
      $error("resource: expected %0d, actual %0d", v.resource, rs);
      fails++;
    end
  endfunction
endclass

module greedy_preference_matcher_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic cfg_we;
  gpm_pkg::num_t cfg_wdata;
  bit   calm;
  int unsigned items_sent;

  gpm_in_if  in_ch();
  gpm_out_if out_ch();

  match_tracker tracker;

  greedy_preference_matcher_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic offer_item(input gpm_pkg::action_t act, input gpm_pkg::num_t cand);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.candidate <= cand;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_item(act, cand);
    items_sent++;
    @(negedge clk);
  endtask

  // Drain pending results and let the pipeline empty before touching the register.
  task automatic write_group_size(input gpm_pkg::num_t v);
    in_ch.valid <= 1'b0;
    while (tracker.waiting() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_group(v);
  endtask

  task automatic present_list(input int unsigned g);
    int unsigned n;
    gpm_pkg::num_t cand;
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) cand = gpm_pkg::num_t'($urandom_range(0, 127));
      else cand = gpm_pkg::num_t'($urandom_range(1, g));
      offer_item(gpm_pkg::ACT_ENTRY, cand);
    end
    offer_item(gpm_pkg::ACT_CLOSE, gpm_pkg::num_t'($urandom_range(0, 127)));
  endtask

  task automatic run_random_phase();
    int unsigned pick;
    int unsigned g;
    int unsigned sets;
    gpm_pkg::num_t gs;
    pick = $urandom_range(0, 19);
    unique case (pick)
      0: gs = 0;
      1: gs = 1;
      2: gs = 64;
      3: gs = 127;
      4: gs = gpm_pkg::num_t'($urandom_range(65, 126));
      5: gs = 2;
      6, 7: gs = gpm_pkg::num_t'($urandom_range(9, 24));
      default: gs = gpm_pkg::num_t'($urandom_range(1, 8));
    endcase
    write_group_size(gs);
    g = (gs == 0) ? 1 : (gs > 64) ? 64 : 32'(gs);
    calm = ($urandom_range(0, 3) == 0);
    sets = (g > 24) ? 1 : $urandom_range(1, 4);
    repeat (sets) begin
      for (int unsigned r = 1; r <= g; r++) present_list(g);
    end
    // Sometimes leave a set unfinished so the next size change can land mid-set.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(0, g - 1)) present_list(g);
    end
  endtask

  // Result side: stall a random number of cycles before each transaction.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      tracker.check_verdict(out_ch.improve, out_ch.requester, out_ch.resource);
      @(negedge clk);
    end
  end

  initial begin
    tracker = new();
    calm = 0;
    items_sent = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = gpm_pkg::ACT_ENTRY;
    in_ch.candidate = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Size one after reset: matched, empty list, out-of-range entries only.
    offer_item(gpm_pkg::ACT_ENTRY, 1);
    offer_item(gpm_pkg::ACT_CLOSE, 0);
    offer_item(gpm_pkg::ACT_CLOSE, 0);
    offer_item(gpm_pkg::ACT_ENTRY, 0);
    offer_item(gpm_pkg::ACT_ENTRY, 127);
    offer_item(gpm_pkg::ACT_CLOSE, 0);
    // Size zero acts as one; second entry after a match is dropped.
    write_group_size(0);
    offer_item(gpm_pkg::ACT_ENTRY, 1);
    offer_item(gpm_pkg::ACT_ENTRY, 1);
    offer_item(gpm_pkg::ACT_CLOSE, 127);
    // Contention on one resource leaves the third requester unmatched.
    write_group_size(3);
    offer_item(gpm_pkg::ACT_ENTRY, 2);
    offer_item(gpm_pkg::ACT_CLOSE, 0);
    offer_item(gpm_pkg::ACT_ENTRY, 2);
    offer_item(gpm_pkg::ACT_ENTRY, 3);
    offer_item(gpm_pkg::ACT_CLOSE, 0);
    offer_item(gpm_pkg::ACT_ENTRY, 2);
    offer_item(gpm_pkg::ACT_ENTRY, 3);
    offer_item(gpm_pkg::ACT_CLOSE, 0);
    // Shrink mid-set: the next close ends the set.
    offer_item(gpm_pkg::ACT_ENTRY, 1);
    offer_item(gpm_pkg::ACT_CLOSE, 0);
    offer_item(gpm_pkg::ACT_CLOSE, 0);
    write_group_size(2);
    offer_item(gpm_pkg::ACT_CLOSE, 0);
    // Shrink mid-set with every remaining resource taken: optimal with zeros.
    write_group_size(3);
    offer_item(gpm_pkg::ACT_ENTRY, 1);
    offer_item(gpm_pkg::ACT_CLOSE, 0);
    offer_item(gpm_pkg::ACT_ENTRY, 2);
    offer_item(gpm_pkg::ACT_CLOSE, 0);
    write_group_size(2);
    offer_item(gpm_pkg::ACT_CLOSE, 0);

    while (items_sent < 925) run_random_phase();

    in_ch.valid <= 1'b0;
    while (tracker.waiting() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (tracker.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
